// ===== hdl/ifft_pkg.sv =====
// shared types and constants for the if frequency trim feedback block
// no dependencies; imported by every module of the block except ifft_ram
package ifft_pkg;

    // field widths fixed by the interface
    localparam int CH_W    = 5;
    localparam int EST_W   = 16;
    localparam int AVG_W   = 16;
    localparam int ACT_W   = 3;
    localparam int NOM_W   = 16;
    localparam int OFS_W   = 10;
    localparam int MIN_W   = 4;
    localparam int CFG_I_W = 2;
    localparam int CFG_D_W = 16;

    // one quotient bit per divider step
    localparam int STEP_W  = $clog2(AVG_W);

    // lowest 802.15.4 channel in the history table
    localparam logic [CH_W-1:0] FIRST_CHANNEL = 5'd11;

    // register reset values
    localparam logic [NOM_W-1:0] NOMINAL_RST = 16'd500;
    localparam logic [OFS_W-1:0] OFFSET_RST  = 10'd25;
    localparam logic [MIN_W-1:0] MIN_EST_RST = 4'd3;

    // configuration register indexes
    typedef enum logic [CFG_I_W-1:0] {
        CFG_NOMINAL = 2'd0,
        CFG_OFFSET  = 2'd1,
        CFG_MIN_EST = 2'd2
    } cfg_index_t;

    // result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_REJECT  = 3'd0,
        ACT_COLLECT = 3'd1,
        ACT_IN_BAND = 3'd2,
        ACT_RAISE   = 3'd3,
        ACT_LOWER   = 3'd4
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SUM,
        S_DIV,
        S_DECIDE,
        S_OUT
    } state_t;

    // datapath controls from the sequencer
    typedef struct packed {
        logic acc_clear;
        logic acc_add;
        logic div_load;
        logic div_step;
    } dp_ctrl_t;

endpackage

// ===== hdl/ifft_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module ifft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ifft_accdiv.sv =====
// accumulator and restoring divider built around one shared add/subtract unit
// depends on ifft_pkg
module ifft_accdiv
    import ifft_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic                         clk,
    input  dp_ctrl_t                     ctrl,
    input  logic [AVG_W-1:0]             rd_data,
    input  logic [$clog2(WINDOW+1)-1:0]  count,
    output logic [AVG_W-1:0]             quotient
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = AVG_W + $clog2(WINDOW);
    localparam int ALU_W = SUM_W + 1;

    logic [SUM_W-1:0] acc_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [AVG_W-1:0] quo_reg;

    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_res;
    logic             no_borrow;
    logic [CNT_W:0]   trial;

    // partial remainder with the next dividend bit shifted in
    assign trial = {rem_reg, quo_reg[AVG_W-1]};

    // shared unit: add for accumulation, subtract for a divider step
    always_comb
    begin
        alu_sub = ctrl.div_step;
        if (ctrl.div_step)
        begin
            alu_a = ALU_W'(trial);
            alu_b = ALU_W'(count);
        end
        else
        begin
            alu_a = ALU_W'(acc_reg);
            alu_b = ALU_W'(rd_data);
        end
        alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}} + (ALU_W+1)'(alu_sub);
    end

    // carry out of a subtract means trial >= count
    assign no_borrow = alu_res[ALU_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= alu_res[SUM_W-1:0];
        end

        if (ctrl.div_load)
        begin
            // upper quotient bits are known zero, the top sum bits are the remainder
            rem_reg <= CNT_W'(acc_reg[SUM_W-1:AVG_W]);
            quo_reg <= acc_reg[AVG_W-1:0];
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= no_borrow ? alu_res[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[AVG_W-2:0], no_borrow};
        end
    end

    assign quotient = quo_reg;

endmodule

// ===== hdl/ifft_seq.sv =====
// sequencer: steps one item through evaluate, sum, divide and decide
// depends on ifft_pkg
module ifft_seq
    import ifft_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  logic                         go_sum,
    input  logic [$clog2(WINDOW+1)-1:0]  count,
    input  logic                         out_fire,
    output state_t                       state,
    output dp_ctrl_t                     ctrl,
    output logic                         rd_en,
    output logic [$clog2(WINDOW)-1:0]    rd_slot
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int POS_W = $clog2(WINDOW);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  slot_reg;
    logic              pend_reg;
    logic [STEP_W-1:0] step_reg;
    logic              sum_done;
    logic              div_done;

    assign sum_done = (slot_reg == count) && !pend_reg;
    assign div_done = (step_reg == STEP_W'(AVG_W - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire)  state_next = S_EVAL;
            S_EVAL:   state_next = go_sum ? S_SUM : S_OUT;
            S_SUM:    if (sum_done) state_next = S_DIV;
            S_DIV:    if (div_done) state_next = S_DECIDE;
            S_DECIDE: state_next = S_OUT;
            S_OUT:    if (out_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.acc_clear = (state_reg == S_EVAL);
        ctrl.acc_add   = (state_reg == S_SUM) && pend_reg;
        ctrl.div_load  = (state_reg == S_SUM) && sum_done;
        ctrl.div_step  = (state_reg == S_DIV);
        rd_en          = (state_reg == S_SUM) && (slot_reg < count);
        rd_slot        = slot_reg[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            pend_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // read data lands in the cycle after the read is issued
            pend_reg  <= rd_en;
            if (state_reg == S_EVAL)
            begin
                slot_reg <= '0;
            end
            else if (rd_en)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            if (ctrl.div_load)
            begin
                step_reg <= '0;
            end
            else if (ctrl.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign state = state_reg;

endmodule

// ===== hdl/rx_if_frequency_trim_feedback.sv =====
// top level of the receiver if frequency trim feedback block
// depends on ifft_pkg, ifft_ram, ifft_accdiv and ifft_seq
//
// usage:
//   input channel (in_valid/in_ready): one beat per received packet with the
//   radio channel and its if zero-crossing count. a zero count or a channel
//   outside the table is rejected. otherwise the count goes into that
//   channel's ring of the last WINDOW counts.
//   output channel (out_valid/out_ready): exactly one beat per input beat with
//   the echoed channel, the action code and the ring's truncated mean or zero.
//   config channel (cfg_valid/cfg_ready): writes nominal count, allowed offset
//   and minimum ring fill; always ready, write only while idle.
// timing:
//   rejected or still collecting: out_valid is set from the evaluate state.
//   averaged: out_valid is set from the decide state, after one ram read per
//   held entry (count, 1 .. WINDOW) is summed and the divider has produced
//   one quotient bit per cycle through the shared add/subtract unit.
//   one item at a time: in_ready is high only when no item is in work, so a
//   new input beat is taken only after the result beat has been taken.
// reset: ring positions and fill flags clear, registers take their defaults;
//   ram contents are not cleared, only entries written since are ever read.
// stall: the result holds on the output until out_ready, input stays blocked.
module rx_if_frequency_trim_feedback
    import ifft_pkg::*;
#(
    parameter int WINDOW   = 10,
    parameter int CHANNELS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // input beats
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CH_W-1:0]    channel,
    input  logic [EST_W-1:0]   crossing_count,
    // result beats
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CH_W-1:0]    channel_out,
    output logic [ACT_W-1:0]   action,
    output logic [AVG_W-1:0]   average,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_I_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0] cfg_data
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

    // configuration registers
    logic [NOM_W-1:0] nominal_reg;
    logic [OFS_W-1:0] offset_reg;
    logic [MIN_W-1:0] min_est_reg;

    // item in work
    logic [CH_W-1:0]  ch_reg;
    logic [EST_W-1:0] est_reg;
    logic [CNT_W-1:0] count_reg;

    // per channel ring state
    logic [POS_W-1:0] pos_reg  [CHANNELS];
    logic             full_reg [CHANNELS];

    // result register
    logic             out_valid_reg;
    logic [CH_W-1:0]  channel_out_reg;
    action_t          action_reg;
    logic [AVG_W-1:0] average_reg;

    logic             in_fire;
    logic             out_fire;
    logic             cfg_fire;
    state_t           state;
    dp_ctrl_t         ctrl;
    logic             rd_en;
    logic [POS_W-1:0] rd_slot;
    logic [AVG_W-1:0] rd_data;
    logic [AVG_W-1:0] quotient;

    logic [CH_W:0]    ch_off;
    logic             ch_ok;
    logic             item_ok;
    logic [IDX_W-1:0] ch_idx;
    logic [ADDR_W-1:0] base_addr;
    logic [POS_W-1:0] cur_pos;
    logic             wrap;
    logic [POS_W-1:0] new_pos;
    logic             full_after;
    logic [CNT_W-1:0] count_now;
    logic             enough;
    logic             go_sum;
    logic [NOM_W:0]   high_bound;
    logic [NOM_W:0]   avg_plus_ofs;
    logic             too_high;
    logic             too_low;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (state == S_IDLE);
    assign cfg_ready = 1'b1;

    // channel range check, table index is channel minus the first channel
    assign ch_off  = {1'b0, ch_reg} - {1'b0, FIRST_CHANNEL};
    assign ch_ok   = (ch_reg >= FIRST_CHANNEL) && (ch_off < (CH_W+1)'(CHANNELS));
    assign item_ok = ch_ok && (est_reg != '0);
    assign ch_idx  = ch_off[IDX_W-1:0];

    assign base_addr = ADDR_W'(ch_idx * WINDOW);

    // ring advance for this write
    assign cur_pos    = pos_reg[ch_idx];
    assign wrap       = (cur_pos == POS_W'(WINDOW - 1));
    assign new_pos    = wrap ? '0 : cur_pos + 1'b1;
    assign full_after = full_reg[ch_idx] || wrap;
    assign count_now  = full_after ? CNT_W'(WINDOW) : CNT_W'(new_pos);

    // a minimum of zero acts as one since the count is never below one here
    assign enough = (CMP_W'(count_now) >= CMP_W'(min_est_reg));
    assign go_sum = item_ok && enough;

    // band check without wrap; lower side as avg + offset < nominal
    assign high_bound   = {1'b0, nominal_reg} + (NOM_W+1)'(offset_reg);
    assign avg_plus_ofs = {1'b0, quotient} + (NOM_W+1)'(offset_reg);
    assign too_high     = ({1'b0, quotient} > high_bound);
    assign too_low      = (avg_plus_ofs < {1'b0, nominal_reg});

    ifft_seq #(
        .WINDOW (WINDOW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .go_sum   (go_sum),
        .count    (count_reg),
        .out_fire (out_fire),
        .state    (state),
        .ctrl     (ctrl),
        .rd_en    (rd_en),
        .rd_slot  (rd_slot)
    );

    ifft_ram #(
        .WIDTH (EST_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   ((state == S_EVAL) && item_ok),
        .wr_addr (base_addr + ADDR_W'(cur_pos)),
        .wr_data (est_reg),
        .rd_en   (rd_en),
        .rd_addr (base_addr + ADDR_W'(rd_slot)),
        .rd_data (rd_data)
    );

    ifft_accdiv #(
        .WINDOW (WINDOW)
    ) u_accdiv (
        .clk      (clk),
        .ctrl     (ctrl),
        .rd_data  (rd_data),
        .count    (count_reg),
        .quotient (quotient)
    );

    // configuration registers, indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg <= NOMINAL_RST;
            offset_reg  <= OFFSET_RST;
            min_est_reg <= MIN_EST_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_NOMINAL: nominal_reg <= cfg_data[NOM_W-1:0];
                CFG_OFFSET:  offset_reg  <= cfg_data[OFS_W-1:0];
                CFG_MIN_EST: min_est_reg <= cfg_data[MIN_W-1:0];
                default:     ;
            endcase
        end
    end

    // item capture and held count
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg  <= channel;
            est_reg <= crossing_count;
        end
        if (state == S_EVAL)
        begin
            count_reg <= count_now;
        end
    end

    // ring positions and fill flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]  <= '0;
                full_reg[i] <= 1'b0;
            end
        end
        else if ((state == S_EVAL) && item_ok)
        begin
            pos_reg[ch_idx]  <= new_pos;
            full_reg[ch_idx] <= full_after;
        end
        else if ((state == S_DECIDE) && (too_high || too_low))
        begin
            // out of band: start the history over
            pos_reg[ch_idx]  <= '0;
            full_reg[ch_idx] <= 1'b0;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (((state == S_EVAL) && !go_sum) || (state == S_DECIDE))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if ((state == S_EVAL) && !go_sum)
        begin
            channel_out_reg <= ch_reg;
            action_reg      <= item_ok ? ACT_COLLECT : ACT_REJECT;
            average_reg     <= '0;
        end
        else if (state == S_DECIDE)
        begin
            channel_out_reg <= ch_reg;
            average_reg     <= quotient;
            priority if (too_high)
            begin
                action_reg <= ACT_RAISE;
            end
            else if (too_low)
            begin
                action_reg <= ACT_LOWER;
            end
            else
            begin
                action_reg <= ACT_IN_BAND;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign action      = action_reg;
    assign average     = average_reg;

    // a pending result and the output state always agree
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg == (state == S_OUT))
        else $error("result valid out of step with sequencer");

    // an input beat is never taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // an average is reported exactly when a mean was taken
    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((action_reg == ACT_REJECT) || (action_reg == ACT_COLLECT))
                       == (average_reg == '0)))
        else $error("average does not match action");

    // in the cycle after an input beat the block is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input ready right after accept");

endmodule
